>>> design/apcs_pkg.sv
// package for the aabb pair collision scanner
// types, request and result codes shared by all design files
package apcs_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SCAN   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] RES_ADDED = 3'd0;
    localparam logic [2:0] RES_FULL  = 3'd1;
    localparam logic [2:0] RES_EVENT = 3'd2;
    localparam logic [2:0] RES_DONE  = 3'd3;
    localparam logic [2:0] RES_ACK   = 3'd4;

    localparam int CFG_REGS = 4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [3:0]         coll_type;
        logic               notify_enable;
        logic [2:0]         target_slot;
    } req_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [2:0] self_slot;
        logic [2:0] other_slot;
        logic       last_item;
    } res_t;

endpackage

>>> design/apcs_fifo.sv
// short request queue between the front and the back part
// depends on apcs_pkg for the request item type
module apcs_fifo
    import apcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_item
);

    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> design/apcs_engine.sv
// back part: collider table, pair scan and result register
// depends on apcs_pkg for item types and codes
module apcs_engine
    import apcs_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int TYPES      = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    input  logic [63:0] mask_reg [CFG_REGS],
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = ((CW > 16) ? CW : 16) + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, pend_reg;
    logic signed [CW-1:0] gx_reg [SLOTS];
    logic signed [CW-1:0] gy_reg [SLOTS];
    logic [14:0]         gw_reg [SLOTS];
    logic [14:0]         gh_reg [SLOTS];
    logic [3:0]          gt_reg [SLOTS];
    logic                gn_reg [SLOTS];
    logic [SW-1:0]       pi_reg, pk_reg;
    logic                ov_valid_reg;
    res_t                res_reg;

    logic                out_free;
    logic [SW-1:0]       free_idx;
    logic                has_free;
    logic                pair_ok, hit, rij, rji, last_pair;
    logic signed [EW-1:0] ax, ay, bx, by, aw, ah, bw, bh;

    function automatic logic reacts(input logic [63:0] m [CFG_REGS],
                                    input logic [3:0] r, input logic [3:0] c);
        logic [5:0] b;
        b = {r[1:0], c};
        if (int'(r) >= TYPES || int'(c) >= TYPES)
        begin
            return 1'b0;
        end
        return m[r[3:2]][b];
    endfunction

    assign out_free  = !ov_valid_reg || res_ready;
    assign res_valid = ov_valid_reg;
    assign res       = res_reg;
    assign req_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                has_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        ax = EW'(gx_reg[pi_reg]);
        ay = EW'(gy_reg[pi_reg]);
        bx = EW'(gx_reg[pk_reg]);
        by = EW'(gy_reg[pk_reg]);
        aw = EW'($signed({1'b0, gw_reg[pi_reg]}));
        ah = EW'($signed({1'b0, gh_reg[pi_reg]}));
        bw = EW'($signed({1'b0, gw_reg[pk_reg]}));
        bh = EW'($signed({1'b0, gh_reg[pk_reg]}));
        hit = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
        pair_ok = valid_reg[pi_reg] && valid_reg[pk_reg] && hit;
        rij = reacts(mask_reg, gt_reg[pi_reg], gt_reg[pk_reg]) && gn_reg[pi_reg];
        rji = reacts(mask_reg, gt_reg[pk_reg], gt_reg[pi_reg]) && gn_reg[pk_reg];
        last_pair = (int'(pi_reg) == SLOTS - 2) && (int'(pk_reg) == SLOTS - 1);
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready && req.req_type == REQ_ADD && has_free)
        begin
            gx_reg[free_idx] <= req.rect_x[CW-1:0];
            gy_reg[free_idx] <= req.rect_y[CW-1:0];
            gw_reg[free_idx] <= req.rect_width;
            gh_reg[free_idx] <= req.rect_height;
            gt_reg[free_idx] <= req.coll_type;
            gn_reg[free_idx] <= req.notify_enable;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready && req.req_type == REQ_SCAN)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN, ST_EMIT:
            begin
                if (out_free)
                begin
                    if (state_reg == ST_SCAN && pair_ok && rij)
                    begin
                        state_next = rji ? ST_EMIT : (last_pair ? ST_DONE : ST_SCAN);
                    end
                    else if (state_reg == ST_EMIT && pair_ok && rji)
                    begin
                        state_next = last_pair ? ST_DONE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = last_pair ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            pend_reg     <= '0;
            pi_reg       <= '0;
            pk_reg       <= '0;
            ov_valid_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
            begin
                ov_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        ov_valid_reg <= 1'b1;
                        res_reg <= '{RES_ACK, 3'd0, 3'd0, 1'b1};
                        case (req.req_type)
                            REQ_ADD:
                            begin
                                if (has_free)
                                begin
                                    valid_reg[free_idx] <= 1'b1;
                                    pend_reg[free_idx]  <= 1'b0;
                                    res_reg <= '{RES_ADDED, 3'(free_idx), 3'd0, 1'b1};
                                end
                                else
                                begin
                                    res_reg <= '{RES_FULL, 3'd0, 3'd0, 1'b1};
                                end
                            end
                            REQ_DELETE:
                            begin
                                if (int'(req.target_slot) < SLOTS)
                                begin
                                    if (valid_reg[req.target_slot[SW-1:0]])
                                    begin
                                        pend_reg[req.target_slot[SW-1:0]] <= 1'b1;
                                    end
                                end
                            end
                            REQ_CLEAR:
                            begin
                                valid_reg <= '0;
                                pend_reg  <= '0;
                            end
                            default:
                            begin
                                ov_valid_reg <= 1'b0;
                                valid_reg <= valid_reg & ~pend_reg;
                                pend_reg  <= '0;
                                pi_reg    <= '0;
                                pk_reg    <= SW'(1);
                            end
                        endcase
                    end
                end
                ST_SCAN, ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (state_reg == ST_SCAN && pair_ok && rij)
                        begin
                            ov_valid_reg <= 1'b1;
                            res_reg <= '{RES_EVENT, 3'(pi_reg), 3'(pk_reg), 1'b0};
                        end
                        else if (state_reg == ST_EMIT && pair_ok && rji)
                        begin
                            ov_valid_reg <= 1'b1;
                            res_reg <= '{RES_EVENT, 3'(pk_reg), 3'(pi_reg), 1'b0};
                        end
                        else if (state_reg == ST_SCAN && pair_ok && rji)
                        begin
                            ov_valid_reg <= 1'b1;
                            res_reg <= '{RES_EVENT, 3'(pk_reg), 3'(pi_reg), 1'b0};
                        end
                        if (!(state_reg == ST_SCAN && pair_ok && rij && rji) && !last_pair)
                        begin
                            if (int'(pk_reg) == SLOTS - 1)
                            begin
                                pi_reg <= pi_reg + SW'(1);
                                pk_reg <= pi_reg + SW'(2);
                            end
                            else
                            begin
                                pk_reg <= pk_reg + SW'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        ov_valid_reg <= 1'b1;
                        res_reg <= '{RES_DONE, 3'd0, 3'd0, 1'b1};
                    end
                end
            endcase
        end
    end

endmodule

>>> design/aabb_pair_collision_scanner.sv
// an accepted item is registered in the queue, then in the engine's result register, before its first result
// add, delete and clear: one item per cycle while results are taken, one result each
// scan: walks each slot pair in turn, one event per direction that reacts, then done
// the engine takes no new request until a scan's done result is issued; the queue holds up to two
// async active-low reset empties the table and zeroes the type mask
// top level: front queue, back engine, mask registers; uses apcs_pkg
module aabb_pair_collision_scanner
    import apcs_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int TYPES      = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] mask_reg [CFG_REGS];
    logic        q_valid, q_ready;
    req_t        q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            mask_reg[cfg_index] <= cfg_data;
        end
    end

    apcs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    apcs_engine #(
        .SLOTS      (SLOTS),
        .TYPES      (TYPES),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_item),
        .mask_reg  (mask_reg),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (out_item)
    );

endmodule

>>> design/apcs_checker.sv
// port-level checks for the aabb pair collision scanner
// depends on apcs_pkg; bound to the top level below
module apcs_checker
    import apcs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input res_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.result_kind <= RES_ACK)
        else $error("bad result kind");

    a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == RES_EVENT |-> !out_item.last_item)
        else $error("event flagged last");

    a_event_slots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == RES_EVENT
            |-> out_item.self_slot != out_item.other_slot)
        else $error("event pairs a slot with itself");

endmodule

bind aabb_pair_collision_scanner apcs_checker u_apcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

>>> tb/testbench.sv
// testbench for aabb_pair_collision_scanner: directed and random requests,
// results checked in order against a built-in model of the collider table
// depends on apcs_pkg and the scanner top level
module testbench;
    import apcs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    req_t        in_item;
    logic        out_valid;
    logic        out_ready;
    res_t        out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    aabb_pair_collision_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        int x;
        int y;
        int w;
        int h;
        logic [3:0] kind;
        logic notify;
    } collider_t;

    logic [63:0] type_mask [4];
    logic        occupied [8];
    logic        marked [8];
    collider_t   colliders [8];

    req_t pending_reqs [$];
    res_t expected_results [$];
    int   mismatches;
    int   received;
    bit   hold_sender;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit reacts(logic [3:0] row, logic [3:0] col);
        logic [63:0] r;
        r = type_mask[row[3:2]];
        return r[row[1:0] * 16 + col];
    endfunction

    function automatic bit boxes_overlap(collider_t a, collider_t b);
        return a.x < b.x + b.w && a.x + a.w > b.x && a.y < b.y + b.h && a.y + a.h > b.y;
    endfunction

    task automatic push_result(logic [2:0] kind, int self_s, int other_s);
        res_t r;
        r.result_kind = kind;
        r.self_slot   = self_s[2:0];
        r.other_slot  = other_s[2:0];
        r.last_item   = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic predict_request(req_t q);
        int slot;
        slot = -1;
        case (q.req_type)
            REQ_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    if (slot < 0 && !occupied[i])
                        slot = i;
                if (slot >= 0)
                begin
                    occupied[slot] = 1'b1;
                    marked[slot] = 1'b0;
                    colliders[slot].x = int'(q.rect_x);
                    colliders[slot].y = int'(q.rect_y);
                    colliders[slot].w = int'(q.rect_width);
                    colliders[slot].h = int'(q.rect_height);
                    colliders[slot].kind = q.coll_type;
                    colliders[slot].notify = q.notify_enable;
                    push_result(RES_ADDED, slot, 0);
                end
                else
                    push_result(RES_FULL, 0, 0);
            end
            REQ_DELETE:
            begin
                if (occupied[q.target_slot])
                    marked[q.target_slot] = 1'b1;
                push_result(RES_ACK, 0, 0);
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    occupied[i] = 1'b0;
                    marked[i] = 1'b0;
                end
                push_result(RES_ACK, 0, 0);
            end
            default:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (marked[i])
                        occupied[i] = 1'b0;
                    marked[i] = 1'b0;
                end
                for (int i = 0; i < 8; i++)
                    for (int k = i + 1; k < 8; k++)
                        if (occupied[i] && occupied[k]
                            && boxes_overlap(colliders[i], colliders[k]))
                        begin
                            if (reacts(colliders[i].kind, colliders[k].kind)
                                && colliders[i].notify)
                                push_result(RES_EVENT, i, k);
                            if (reacts(colliders[k].kind, colliders[i].kind)
                                && colliders[k].notify)
                                push_result(RES_EVENT, k, i);
                        end
                push_result(RES_DONE, 0, 0);
            end
        endcase
        expected_results[$].last_item = 1'b1;
    endtask

    function automatic req_t make_req(logic [1:0] kind);
        req_t q;
        q.req_type      = kind;
        q.rect_x        = 16'($urandom);
        q.rect_y        = 16'($urandom);
        q.rect_width    = 15'($urandom);
        q.rect_height   = 15'($urandom);
        q.coll_type     = 4'($urandom);
        q.notify_enable = 1'($urandom);
        q.target_slot   = 3'($urandom);
        return q;
    endfunction

    // small boxes in a narrow field so that pairs overlap often
    function automatic req_t make_add(int span);
        req_t q;
        q = make_req(REQ_ADD);
        q.rect_x      = 16'($urandom_range(2 * span) - span);
        q.rect_y      = 16'($urandom_range(2 * span) - span);
        q.rect_width  = 15'($urandom_range(span));
        q.rect_height = 15'($urandom_range(span));
        return q;
    endfunction

    // driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_gap   <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (pending_reqs.size() > 0 && !hold_sender)
        begin
            in_valid <= 1'b1;
            in_item  <= pending_reqs.pop_front();
            in_gap   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(19);
        end
        else
            in_valid <= 1'b0;
    end

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            predict_request(in_item);

    // monitor
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                received++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_item);
                end
                else
                begin
                    res_t want;
                    want = expected_results.pop_front();
                    if (want !== out_item)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %p, got %p",
                                received, want, out_item);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else if (out_valid && out_ready)
            begin
                out_gap   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(19);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_mask(int idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= value;
        type_mask[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_random_phase(int count, int span);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                pending_reqs.push_back(make_add(span));
            else if (pick < 62)
                pending_reqs.push_back(make_req(REQ_DELETE));
            else if (pick < 90)
                pending_reqs.push_back(make_req(REQ_SCAN));
            else if (pick < 95)
                pending_reqs.push_back(make_req(REQ_CLEAR));
            else
                pending_reqs.push_back(make_req(REQ_ADD));
        end
    endtask

    initial
    begin
        req_t q;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        received = 0;
        hold_sender = 1'b0;
        for (int i = 0; i < 4; i++)
            type_mask[i] = '0;
        for (int i = 0; i < 8; i++)
        begin
            occupied[i] = 1'b0;
            marked[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // all types react to all types
        for (int i = 0; i < 4; i++)
            write_mask(i, '1);

        // fill past full with extreme boxes, delete, add, delete, two scans, clear, then delete, scan, adds and scan
        for (int i = 0; i < 9; i++)
        begin
            q = make_req(REQ_ADD);
            q.rect_x = (i % 2) ? 16'sh7fff : 16'sh8000;
            q.rect_y = (i % 2) ? 16'sh7fff : 16'sh8000;
            q.rect_width = (i < 4) ? 15'h7fff : 15'd0;
            q.rect_height = 15'h7fff;
            q.notify_enable = i != 3;
            q.coll_type = 4'(i);
            pending_reqs.push_back(q);
        end
        q = make_req(REQ_DELETE);
        q.target_slot = 3'd7;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_add(10));
        q.target_slot = 3'd2;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(REQ_SCAN));
        pending_reqs.push_back(make_req(REQ_SCAN));
        pending_reqs.push_back(make_req(REQ_CLEAR));
        q.target_slot = 3'd0;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(REQ_SCAN));
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(make_add(4));
        pending_reqs.push_back(make_req(REQ_SCAN));
        wait_drained();

        // new masks and a random phase, then the sender held with requests queued
        write_mask(0, 64'h0000_0000_0000_0001);
        write_mask(1, '0);
        write_mask(2, 64'h8000_0000_0000_0000);
        write_mask(3, 64'hffff_0000_0000_ffff);
        load_random_phase(60, 200);
        wait_drained();
        hold_sender = 1'b1;
        load_random_phase(3, 50);
        repeat (30) @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < 4; i++)
                write_mask(i, {$urandom, $urandom});
            load_random_phase(45, (p == 2) ? 30000 : 300);
            wait_drained();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
